FILE: hw/rtl/sliding_window_maximum_defines.svh
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define SWM_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SWM_ASSERT_RST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: hw/rtl/swm_pkg.sv
// Shared widths, defaults and cell control type for the sliding window maximum.
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int WIN_W          = 11;
  localparam int MAX_WINDOW_DEF = 64;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic             advance;
    logic [WIN_W-1:0] win;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/swm_cell.sv
// One comparator cell: holds the maximum of the last INDEX+1 samples.
module swm_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  swm_pkg::sample_t    sample,
  input  swm_pkg::sample_t    prev_max,
  output swm_pkg::sample_t    max_q,
  output swm_pkg::sample_t    tap_max
);

  swm_pkg::sample_t max_next;
  logic             tap;

  assign max_next = (prev_max > sample) ? prev_max : sample;
  assign tap      = (ctrl.win == swm_pkg::WIN_W'(INDEX + 1));
  // Drive zero unless this cell covers the configured window.
  assign tap_max  = tap ? max_next : '0;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      max_q <= max_next;
    end
  end

endmodule

FILE: hw/rtl/swm_out_fifo.sv
// Two-entry output queue that decouples the result side from the cell row.
module swm_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  swm_pkg::sample_t push_data,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output swm_pkg::sample_t data
);

  logic [1:0]       count;
  logic [1:0]       count_next;
  swm_pkg::sample_t slot0;
  swm_pkg::sample_t slot1;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign data  = slot0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // Advance the queue; a new word lands in the head when it empties.
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

FILE: hw/rtl/sliding_window_maximum.sv
// A result word enters the output queue in the cycle after its sample is accepted.
// One sample per cycle while s_tready is high; each cell updates once per accepted sample.
// A two-word output queue keeps s_tready high while one result waits to be taken.
// Reset (rst, synchronous): clears the fill count and output queue, window size becomes 1.
// Cell contents are not reset; the fill count keeps them from reaching the output.
module sliding_window_maximum #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [swm_pkg::DATA_W-1:0] s_tdata,  // [31:0] sample
  input  logic [0:0]                 s_tuser,  // [0] restart
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [swm_pkg::DATA_W-1:0] m_tdata,  // [31:0] window_max
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_data
);

  logic                      accept;
  logic                      fifo_full;
  logic [swm_pkg::WIN_W-1:0] win_eff;
  logic [swm_pkg::WIN_W-1:0] win_cfg;
  logic [swm_pkg::WIN_W-1:0] fill_count;
  logic [swm_pkg::WIN_W-1:0] fill_base;
  logic [swm_pkg::WIN_W-1:0] fill_next;
  logic                      emit;
  swm_pkg::sample_t          sample;
  swm_pkg::sample_t          result;
  swm_pkg::cell_ctrl_t       ctrl;
  swm_pkg::sample_t          max_q   [MAX_WINDOW];
  swm_pkg::sample_t          tap_max [MAX_WINDOW];

  assign cfg_ready = 1'b1;
  assign s_tready  = !fifo_full;
  assign accept    = s_tvalid && s_tready;
  assign sample    = s_tdata;

  // Clamp the written size into 1..MAX_WINDOW.
  always_comb begin
    win_cfg = swm_pkg::WIN_W'(cfg_data);
    if (cfg_data == '0) begin
      win_cfg = swm_pkg::WIN_W'(1);
    end else if (int'(cfg_data) > MAX_WINDOW) begin
      win_cfg = swm_pkg::WIN_W'(MAX_WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_eff <= swm_pkg::WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      win_eff <= win_cfg;
    end
  end

  // Restart drops history: count from zero before adding this sample.
  always_comb begin
    fill_base = s_tuser[0] ? '0 : fill_count;
    fill_next = fill_base;
    if (fill_base != swm_pkg::WIN_W'(MAX_WINDOW)) begin
      fill_next = fill_base + swm_pkg::WIN_W'(1);
    end
  end

  assign emit = accept && (fill_next >= win_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_next;
    end
  end

  assign ctrl.advance = accept;
  assign ctrl.win     = win_eff;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swm_pkg::sample_t prev;
    if (k == 0) begin : g_head
      assign prev = sample;
    end else begin : g_link
      assign prev = max_q[k-1];
    end
    swm_cell #(
      .INDEX(k)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .sample  (sample),
      .prev_max(prev),
      .max_q   (max_q[k]),
      .tap_max (tap_max[k])
    );
  end

  // Exactly one cell matches the window, so an OR picks its value.
  always_comb begin
    result = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      result = result | tap_max[k];
    end
  end

  swm_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (emit),
    .push_data(result),
    .pop      (m_tvalid && m_tready),
    .valid    (m_tvalid),
    .full     (fifo_full),
    .data     (m_tdata)
  );

endmodule

FILE: hw/rtl/swm_checker.sv
// Port-level checks for the sliding window maximum, bound to the top level.
`include "sliding_window_maximum_defines.svh"

module swm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [swm_pkg::DATA_W-1:0] m_tdata
);

  `SWM_ASSERT_RST(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `SWM_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
  `SWM_ASSERT(a_stall_cause, clk, rst, !s_tready |-> m_tvalid, "input stalled with empty output")
  `SWM_ASSERT(a_no_invent, clk, rst, !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid, "word without sample")

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the sliding window maximum filter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef swm_pkg::sample_t sample_t;

  localparam int DATA_W         = swm_pkg::DATA_W;
  localparam int CFG_W          = swm_pkg::CFG_W;
  localparam int MAX_WIN        = swm_pkg::MAX_WINDOW_DEF;
  localparam int RESULT_LAT     = 1;
  localparam int SETTLE_CYCLES  = RESULT_LAT + 3;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_ITEMS   = 340;

  localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
  localparam sample_t SAMPLE_MAX = sample_t'(32'h7FFF_FFFF);

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [31:0] sample
  logic [0:0]        s_tuser = '0;   // [0] restart
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [31:0] window_max
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // Predictor state
  sample_t          ring_mem [MAX_WIN];
  int unsigned      fill_cnt = 0;
  int unsigned      wr_pos = 0;
  logic [CFG_W-1:0] win_setting = 1;

  sample_t  expected_max_q [$];
  int       fail_count = 0;
  int       samples_sent = 0;
  int       restarts_sent = 0;
  int       maxima_checked = 0;
  int       cfg_writes = 0;
  int       quiet_cycles = 0;

  // Sender burst control
  bit       gaps_on = 1'b0;
  int       burst_left = 0;

  // Receiver control
  rx_mode_t rx_mode = RX_ALWAYS;
  int       holdoff_req = 0;
  int       holdoff_seen = 0;
  int       hold_left = 0;
  int       rx_tick = 0;

  sliding_window_maximum dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned eff_window(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIN) return MAX_WIN;
    return w;
  endfunction

  function automatic bit predict_window_max(input sample_t s, input bit restart,
                                            output sample_t best);
    int unsigned w;
    int unsigned pos;
    w = eff_window(win_setting);
    if (restart) begin
      fill_cnt = 0;
      wr_pos = 0;
    end
    ring_mem[wr_pos] = s;
    wr_pos = (wr_pos + 1) % MAX_WIN;
    if (fill_cnt < MAX_WIN) fill_cnt++;
    best = s;
    if (fill_cnt < w) return 1'b0;
    pos = wr_pos;
    for (int unsigned i = 0; i < w; i++) begin
      pos = (pos + MAX_WIN - 1) % MAX_WIN;
      if (ring_mem[pos] > best) best = ring_mem[pos];
    end
    return 1'b1;
  endfunction

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) return sample_t'($urandom);
    if (pick < 14) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MIN;
        1: return SAMPLE_MAX;
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    // narrow range so that equal maxima show up often
    return sample_t'(int'($urandom_range(0, 8)) - 4);
  endfunction

  task automatic push_sample(input sample_t s, input bit restart);
    sample_t best;
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    if (predict_window_max(s, restart, best)) expected_max_q = {expected_max_q, best};
    samples_sent++;
    if (restart) restarts_sent++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  // Drop valid, let every expected word arrive, then let the pipeline settle.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    wait (expected_max_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_setting = w;
    cfg_writes++;
  endtask

  task automatic test_pass_through();
    // window is 1 out of reset
    push_sample(SAMPLE_MIN, 1'b1);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(-1), 1'b1);
    push_sample(sample_t'(1), 1'b0);
  endtask

  task automatic test_zero_window();
    wait_results();
    write_window(0);
    push_sample(sample_t'(-5), 1'b1);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(sample_t'(-5), 1'b0);
  endtask

  task automatic test_short_sequence();
    wait_results();
    write_window(5);
    push_sample(sample_t'(100), 1'b1);
    push_sample(sample_t'(200), 1'b0);
    push_sample(sample_t'(300), 1'b0);
    // new run with repeated maxima
    push_sample(sample_t'(7), 1'b1);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
  endtask

  task automatic test_window_change();
    wait_results();
    write_window(3);
    push_sample(sample_t'(-1), 1'b1);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(sample_t'(-2), 1'b0);
    push_sample(sample_t'(5), 1'b0);
    // grow the window while keeping history
    wait_results();
    write_window(6);
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(2), 1'b0);
    // shrink it again
    wait_results();
    write_window(2);
    push_sample(sample_t'(-9), 1'b0);
  endtask

  task automatic test_backpressure();
    wait_results();
    write_window(2);
    gaps_on = 1'b0;
    holdoff_req++;
    for (int i = 0; i < 24; i++) push_sample(rand_sample(), i == 0);
    // hold the sender until the backlog is gone
    wait_results();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    for (int i = 0; i < 10; i++) push_sample(rand_sample(), 1'b0);
  endtask

  task automatic test_random_phases();
    int               sent;
    int               phase;
    int unsigned      w_eff;
    int unsigned      len;
    int unsigned      pick;
    logic [CFG_W-1:0] w;
    bit               restart;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: w = CFG_W'(MAX_WIN);
        1: w = '1;
        2: w = CFG_W'(100);
        3: w = CFG_W'(1);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 5) w = CFG_W'($urandom_range(0, 8));
          else if (pick < 8) w = CFG_W'($urandom_range(9, 40));
          else w = CFG_W'($urandom_range(41, 127));
        end
      endcase
      wait_results();
      write_window(w);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      w_eff = eff_window(w);
      len = w_eff + $urandom_range(4, 24);
      for (int unsigned i = 0; i < len; i++) begin
        // first word usually restarts; otherwise history carries over
        if (i == 0) restart = ($urandom_range(0, 3) != 0);
        else restart = ($urandom_range(0, 2 * w_eff + 8) == 0);
        push_sample(rand_sample(), restart);
      end
      sent += len;
      phase++;
    end
  endtask

  // Receiver: a long hold-off on request, otherwise the current stall pattern.
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      hold_left = HOLDOFF_CYCLES;
    end
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_tready <= (rx_tick % 7) < 4;
        default:    m_tready <= (rx_tick % 4) == 0;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    sample_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_max_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual %0d", $time,
                 sample_t'(m_tdata));
      end else begin
        want = expected_max_q.pop_front();
        maxima_checked++;
        if (sample_t'(m_tdata) !== want) begin
          fail_count++;
          $display("%0t: window_max mismatch, expected %0d, actual %0d", $time,
                   want, sample_t'(m_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no word moved for %0d cycles, %0d words still expected", $time,
             QUIET_LIMIT, expected_max_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pass_through();
    test_zero_window();
    test_short_sequence();
    test_window_change();
    test_backpressure();
    test_random_phases();
    wait_results();
    if (expected_max_q.size() != 0) begin
      fail_count++;
      $display("%0t: words left over, expected %0d more, actual none", $time,
               expected_max_q.size());
    end
    $display("Sent %0d samples (%0d restarts) over %0d window settings; checked %0d maxima.",
             samples_sent, restarts_sent, cfg_writes, maxima_checked);
    $display("Windows 0, 1, 64 and above 64, mid-run resizing, short runs and a %0d-cycle stall.",
             HOLDOFF_CYCLES);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_out_fifo.sv
hw/rtl/sliding_window_maximum.sv
hw/rtl/swm_checker.sv
sim/tb_top.sv
